// ----- hw/rtl/bta_pkg.sv -----
`default_nettype none
package bta_pkg;

  localparam int TS_W    = 56;
  localparam int PRICE_W = 32;
  localparam int AVG_W   = 40;
  localparam int LEN_W   = 37;
  localparam int PER_W   = 8;
  localparam int FRAC_W  = 8;
  localparam int DIV_CW  = $clog2(TS_W + 1);
  localparam int IDX_W   = 2;
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam logic [LEN_W-1:0] BAR_LEN_RST = LEN_W'(900000000);
  localparam logic [PER_W-1:0] PERIOD_RST  = PER_W'(10);

  typedef enum logic [IDX_W-1:0] {
    REG_BAR_LEN = 2'd0,
    REG_PERIOD  = 2'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BKT,
    S_CLS,
    S_BAR,
    S_PRV,
    S_PWT,
    S_OUT
  } back_state_t;

  typedef struct packed {
    logic [TS_W-1:0]    ts;
    logic [PRICE_W-1:0] price;
  } tick_t;

  typedef struct packed {
    logic              start;
    logic [TS_W-1:0]   dividend;
    logic [LEN_W-1:0]  divisor;
    logic [DIV_CW-1:0] nbits;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [TS_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic             neg;
    logic [AVG_W-1:0] mag;
  } wilder_t;

  function automatic logic [PRICE_W-1:0] abs_diff(input logic [PRICE_W-1:0] a,
                                                  input logic [PRICE_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [PRICE_W-1:0] true_range(input logic [PRICE_W-1:0] hi,
                                                    input logic [PRICE_W-1:0] lo,
                                                    input logic [PRICE_W-1:0] pc,
                                                    input logic               have_pc);
    logic [PRICE_W-1:0] tr;
    logic [PRICE_W-1:0] d1;
    logic [PRICE_W-1:0] d2;
    tr = hi - lo;
    d1 = abs_diff(hi, pc);
    d2 = abs_diff(lo, pc);
    if (have_pc) begin
      if (d1 > tr) tr = d1;
      if (d2 > tr) tr = d2;
    end
    return tr;
  endfunction

  function automatic wilder_t wilder_setup(input logic [AVG_W-1:0]   avg,
                                           input logic [PRICE_W-1:0] tr);
    wilder_t w;
    logic [AVG_W-1:0] target;
    target = {tr, {FRAC_W{1'b0}}};
    w.neg  = avg > target;
    w.mag  = w.neg ? avg - target : target - avg;
    return w;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/bta_tick_if.sv -----
`default_nettype none
interface bta_tick_if;
  import bta_pkg::*;

  logic               valid;
  logic               ready;
  logic [TS_W-1:0]    timestamp_us;
  logic [PRICE_W-1:0] price;

  modport source (output valid, output timestamp_us, output price, input ready);
  modport sink   (input valid, input timestamp_us, input price, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/bta_res_if.sv -----
`default_nettype none
interface bta_res_if;
  import bta_pkg::*;

  logic             valid;
  logic             ready;
  logic [AVG_W-1:0] completed_average;
  logic [AVG_W-1:0] preview_average;
  logic             average_ready;
  logic             bar_closed;

  modport source (output valid, output completed_average, output preview_average,
                  output average_ready, output bar_closed, input ready);
  modport sink   (input valid, input completed_average, input preview_average,
                  input average_ready, input bar_closed, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/bta_cfg_if.sv -----
`default_nettype none
interface bta_cfg_if;
  import bta_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [LEN_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/bucketed_true_range_wilder_atr.sv -----
// Each tick word takes a bucket division (56 steps) on the shared one-bit-per-cycle divider;
//   a tick that closes a bar on a seeded average takes one extra 40-step division, and every
//   tick after the first bar closes takes a 40-step preview division. A 2-word queue
//   buffers input while the back end works on one tick at a time, and zero-price words
//   are accepted and dropped with no result.
// Reset: synchronous active-low rst_n clears the bar-open, previous-close and seeded flags
//   and the average; bar length returns to 900000000 us and period to 10.
`default_nettype none
module bucketed_true_range_wilder_atr (
  input  logic       clk,
  input  logic       rst_n,
  bta_tick_if.sink   in_ch,
  bta_res_if.source  out_ch,
  bta_cfg_if.sink    cfg_ch
);
  import bta_pkg::*;

  logic [LEN_W-1:0] bar_len_r;
  logic [PER_W-1:0] period_r;
  logic             q_valid;
  tick_t            q_data;
  logic             q_pop;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bar_len_r <= BAR_LEN_RST;
      period_r  <= PERIOD_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_BAR_LEN: bar_len_r <= cfg_ch.data;
        REG_PERIOD:  period_r  <= cfg_ch.data[PER_W-1:0];
        default: ;
      endcase
    end
  end

  bta_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop)
  );

  bta_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  bta_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .bar_len (bar_len_r),
    .period  (period_r),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .div_req (div_req),
    .div_rsp (div_rsp),
    .out_ch  (out_ch)
  );

`ifndef SYNTHESIS
  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_close_seeds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.bar_closed) |-> out_ch.average_ready)
    else $error("bar closed without a ready average");

  a_unseeded_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.average_ready) |->
      (out_ch.completed_average == '0 && out_ch.preview_average == '0))
    else $error("nonzero average before first bar closed");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/bta_front.sv -----
`default_nettype none
module bta_front (
  input  logic           clk,
  input  logic           rst_n,
  bta_tick_if.sink       in_ch,
  output logic           q_valid,
  output bta_pkg::tick_t q_data,
  input  logic           q_pop
);
  import bta_pkg::*;

  tick_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r;
  logic [Q_AW-1:0]  rd_ptr_r;
  logic [Q_CW-1:0]  cnt_r;
  logic [Q_CW-1:0]  cnt_nxt;
  logic             push;
  logic             pop;

  assign in_ch.ready = (cnt_r != Q_CW'(Q_DEPTH));
  // drop zero-price words at the door
  assign push        = in_ch.valid && in_ch.ready && (in_ch.price != '0);
  assign q_valid     = (cnt_r != '0);
  assign pop         = q_pop && q_valid;
  assign q_data      = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + Q_CW'(1);
    else if (!push && pop) cnt_nxt = cnt_r - Q_CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + Q_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r].ts    <= in_ch.timestamp_us;
      mem_r[wr_ptr_r].price <= in_ch.price;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/bta_div.sv -----
`default_nettype none
module bta_div (
  input  logic              clk,
  input  logic              rst_n,
  input  bta_pkg::div_req_t req,
  output bta_pkg::div_rsp_t rsp
);
  import bta_pkg::*;

  logic [TS_W-1:0]   q_r;
  logic [LEN_W-1:0]  rem_r;
  logic [LEN_W-1:0]  d_r;
  logic [DIV_CW-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [LEN_W:0]    sh;
  logic [LEN_W:0]    dif;
  logic              ge;

  assign sh  = {rem_r, q_r[TS_W-1]};
  assign dif = sh - {1'b0, d_r};
  assign ge  = (sh >= {1'b0, d_r});

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= req.nbits;
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CW'(1);
        if (cnt_r == DIV_CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      q_r   <= req.dividend;
      d_r   <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      q_r   <= {q_r[TS_W-2:0], ge};
      rem_r <= ge ? dif[LEN_W-1:0] : sh[LEN_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/bta_back.sv -----
`default_nettype none
module bta_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [bta_pkg::LEN_W-1:0]  bar_len,
  input  logic [bta_pkg::PER_W-1:0]  period,
  input  logic                       q_valid,
  input  bta_pkg::tick_t             q_data,
  output logic                       q_pop,
  output bta_pkg::div_req_t          div_req,
  input  bta_pkg::div_rsp_t          div_rsp,
  bta_res_if.source                  out_ch
);
  import bta_pkg::*;

  localparam int PAD_W = TS_W - AVG_W;

  back_state_t        state_r;
  back_state_t        state_nxt;

  logic [PRICE_W-1:0] price_r;
  logic [TS_W-1:0]    bucket_r;
  logic               closing_r;
  logic               new_bar_r;
  logic               neg_r;
  logic               bar_open_r;
  logic [TS_W-1:0]    cur_bucket_r;
  logic [PRICE_W-1:0] high_r;
  logic [PRICE_W-1:0] low_r;
  logic [PRICE_W-1:0] close_r;
  logic [PRICE_W-1:0] prev_r;
  logic               have_prev_r;
  logic [AVG_W-1:0]   avg_r;
  logic               seeded_r;
  logic [AVG_W-1:0]   preview_r;

  logic               out_valid_r;
  logic [AVG_W-1:0]   out_comp_r;
  logic [AVG_W-1:0]   out_prev_r;
  logic               out_ready_r;
  logic               out_closed_r;

  logic [LEN_W-1:0]   len_eff;
  logic [PER_W-1:0]   per_eff;
  logic [PRICE_W-1:0] tr_now;
  wilder_t            ws;
  logic               closing;
  logic               out_free;
  logic               wstart;
  logic [AVG_W-1:0]   wq;
  logic [AVG_W-1:0]   w_next;

  assign len_eff  = (bar_len == '0) ? LEN_W'(1) : bar_len;
  assign per_eff  = (period == '0) ? PER_W'(1) : period;
  assign tr_now   = true_range(high_r, low_r, prev_r, have_prev_r);
  assign ws       = wilder_setup(avg_r, tr_now);
  assign closing  = bar_open_r && (div_rsp.quotient != cur_bucket_r);
  assign out_free = !out_valid_r || out_ch.ready;
  assign wq       = div_rsp.quotient[AVG_W-1:0];
  assign w_next   = neg_r ? avg_r - wq : avg_r + wq;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (q_valid) state_nxt = S_BKT;
      S_BKT: begin
        if (div_rsp.done) state_nxt = (closing && seeded_r) ? S_CLS : S_BAR;
      end
      S_CLS:  if (div_rsp.done) state_nxt = S_BAR;
      S_BAR:  state_nxt = S_PRV;
      S_PRV:  state_nxt = seeded_r ? S_PWT : S_OUT;
      S_PWT:  if (div_rsp.done) state_nxt = S_OUT;
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    q_pop            = 1'b0;
    wstart           = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = q_data.ts;
    div_req.divisor  = len_eff;
    div_req.nbits    = DIV_CW'(TS_W);
    unique case (state_r)
      S_IDLE: begin
        q_pop         = q_valid;
        div_req.start = q_valid;
      end
      S_BKT: wstart = div_rsp.done && closing && seeded_r;
      S_PRV: wstart = seeded_r;
      default: ;
    endcase
    if (wstart) begin
      div_req.start    = 1'b1;
      div_req.dividend = {ws.mag, {PAD_W{1'b0}}};
      div_req.divisor  = {{(LEN_W-PER_W){1'b0}}, per_eff};
      div_req.nbits    = DIV_CW'(AVG_W);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bar_open_r  <= 1'b0;
      have_prev_r <= 1'b0;
      seeded_r    <= 1'b0;
      avg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_BKT && div_rsp.done && closing && !seeded_r) begin
        avg_r    <= {tr_now, {FRAC_W{1'b0}}};
        seeded_r <= 1'b1;
      end
      if (state_r == S_CLS && div_rsp.done) avg_r <= w_next;
      if (state_r == S_BAR && new_bar_r) begin
        bar_open_r <= 1'b1;
        if (closing_r) have_prev_r <= 1'b1;
      end
      if (state_r == S_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) price_r <= q_data.price;
    if (wstart) neg_r <= ws.neg;
    if (state_r == S_BKT && div_rsp.done) begin
      bucket_r  <= div_rsp.quotient;
      closing_r <= closing;
      new_bar_r <= !bar_open_r || closing;
    end
    if (state_r == S_BAR) begin
      close_r <= price_r;
      if (new_bar_r) begin
        cur_bucket_r <= bucket_r;
        high_r       <= price_r;
        low_r        <= price_r;
        if (closing_r) prev_r <= close_r;
      end else begin
        if (price_r > high_r) high_r <= price_r;
        if (price_r < low_r)  low_r  <= price_r;
      end
    end
    if (state_r == S_PRV && !seeded_r) preview_r <= avg_r;
    if (state_r == S_PWT && div_rsp.done) preview_r <= w_next;
    if (state_r == S_OUT && out_free) begin
      out_comp_r   <= avg_r;
      out_prev_r   <= preview_r;
      out_ready_r  <= seeded_r;
      out_closed_r <= closing_r;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.completed_average = out_comp_r;
  assign out_ch.preview_average   = out_prev_r;
  assign out_ch.average_ready     = out_ready_r;
  assign out_ch.bar_closed        = out_closed_r;

endmodule
`default_nettype wire

// ----- test/bucketed_true_range_wilder_atr_checker.sv -----
`timescale 1ns / 1ps
module bucketed_true_range_wilder_atr_checker (
  input  logic clk,
  input  logic rst_n,
  bta_tick_if  tick,
  bta_res_if   res,
  bta_cfg_if   cfg,
  output int   errors,
  output int   pending
);
  import bta_pkg::*;

  typedef struct packed {
    logic [AVG_W-1:0] completed;
    logic [AVG_W-1:0] preview;
    logic             seeded;
    logic             closed;
  } atr_word_t;

  atr_word_t          atr_due_q[$];
  atr_word_t          due;
  logic [LEN_W-1:0]   bar_len;
  logic [PER_W-1:0]   period;
  logic               open_bar;
  logic [TS_W-1:0]    bucket_now;
  logic [PRICE_W-1:0] hi;
  logic [PRICE_W-1:0] lo;
  logic [PRICE_W-1:0] last_px;
  logic [PRICE_W-1:0] prev_close;
  logic               have_prev;
  logic [AVG_W-1:0]   atr;
  logic               seeded;
  int                 mismatches;

  function automatic logic [PRICE_W-1:0] bar_span(input logic [PRICE_W-1:0] h,
                                                  input logic [PRICE_W-1:0] l);
    logic [PRICE_W-1:0] r;
    logic [PRICE_W-1:0] dh;
    logic [PRICE_W-1:0] dl;
    r  = h - l;
    dh = (h > prev_close) ? h - prev_close : prev_close - h;
    dl = (l > prev_close) ? l - prev_close : prev_close - l;
    if (have_prev) begin
      if (dh > r) r = dh;
      if (dl > r) r = dl;
    end
    return r;
  endfunction

  function automatic logic [AVG_W-1:0] smooth(input logic [AVG_W-1:0]   avg,
                                              input logic [PRICE_W-1:0] tr);
    longint divisor;
    longint delta;
    divisor = (period == '0) ? 64'sd1 : longint'({56'd0, period});
    delta   = (longint'({16'd0, tr, 8'd0}) - longint'({24'd0, avg})) / divisor;
    return AVG_W'(longint'({24'd0, avg}) + delta);
  endfunction

  task automatic fold_tick(input logic [TS_W-1:0] ts, input logic [PRICE_W-1:0] px);
    logic [TS_W-1:0]    len;
    logic [TS_W-1:0]    bkt;
    logic [PRICE_W-1:0] tr;
    logic               shut;
    atr_word_t          w;
    len  = (bar_len == '0) ? TS_W'(1) : TS_W'(bar_len);
    bkt  = ts / len;
    shut = 1'b0;
    if (!open_bar) begin
      open_bar   = 1'b1;
      bucket_now = bkt;
      hi         = px;
      lo         = px;
    end else if (bkt != bucket_now) begin
      tr = bar_span(hi, lo);
      if (!seeded) begin
        atr    = {tr, 8'd0};
        seeded = 1'b1;
      end else begin
        atr = smooth(atr, tr);
      end
      prev_close = last_px;
      have_prev  = 1'b1;
      bucket_now = bkt;
      hi         = px;
      lo         = px;
      shut       = 1'b1;
    end
    last_px = px;
    if (px > hi) hi = px;
    if (px < lo) lo = px;
    w.completed = atr;
    w.preview   = seeded ? smooth(atr, bar_span(hi, lo)) : atr;
    w.seeded    = seeded;
    w.closed    = shut;
    atr_due_q.insert(atr_due_q.size(), w);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      bar_len    = BAR_LEN_RST;
      period     = PERIOD_RST;
      open_bar   = 1'b0;
      bucket_now = '0;
      hi         = '0;
      lo         = '0;
      last_px    = '0;
      prev_close = '0;
      have_prev  = 1'b0;
      atr        = '0;
      seeded     = 1'b0;
      mismatches = 0;
      atr_due_q.delete();
      errors  <= 0;
      pending <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg_reg_t'(cfg.index))
          REG_BAR_LEN: bar_len = cfg.data;
          REG_PERIOD:  period  = cfg.data[PER_W-1:0];
          default: ;
        endcase
      end
      if (res.valid && res.ready) begin
        if (atr_due_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t unexpected word: completed %0d preview %0d ready %0b closed %0b",
                     $realtime, res.completed_average, res.preview_average,
                     res.average_ready, res.bar_closed);
        end else begin
          due = atr_due_q.pop_front();
          if (res.completed_average !== due.completed || res.preview_average !== due.preview ||
              res.average_ready !== due.seeded || res.bar_closed !== due.closed) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t word mismatch: expected completed %0d preview %0d ready %0b closed %0b",
                       $realtime, due.completed, due.preview, due.seeded, due.closed);
              $display("%0t                got completed %0d preview %0d ready %0b closed %0b",
                       $realtime, res.completed_average, res.preview_average,
                       res.average_ready, res.bar_closed);
            end
          end
        end
      end
      if (tick.valid && tick.ready && tick.price != '0)
        fold_tick(tick.timestamp_us, tick.price);
      errors  <= mismatches;
      pending <= atr_due_q.size();
    end
  end

endmodule

// ----- test/bucketed_true_range_wilder_atr_tb.sv -----
`timescale 1ns / 1ps
module bucketed_true_range_wilder_atr_tb;
  import bta_pkg::*;

  localparam int              CYCLE_LIMIT = 2_000_000;
  localparam int              PHASE_TICKS = 215;
  localparam logic [TS_W-1:0] TS_TOP      = '1;

  logic               clk = 1'b0;
  logic               rst_n;
  int                 fail_count;
  int                 pending;
  int                 cycles = 0;
  int                 rx_words;
  logic               tx_calm;
  logic               rx_calm;
  logic [TS_W-1:0]    ts_now;
  logic [PRICE_W-1:0] px_base;

  bta_tick_if tick_ch();
  bta_res_if  res_ch();
  bta_cfg_if  cfg_ch();

  bucketed_true_range_wilder_atr uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (tick_ch),
    .out_ch (res_ch),
    .cfg_ch (cfg_ch)
  );

  bucketed_true_range_wilder_atr_checker chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .tick    (tick_ch),
    .res     (res_ch),
    .cfg     (cfg_ch),
    .errors  (fail_count),
    .pending (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("bucketed_true_range_wilder_atr verification failed");
      $finish;
    end
  end

  function automatic logic [63:0] draw_upto(input logic [63:0] top);
    return {$urandom, $urandom} % (top + 64'd1);
  endfunction

  task automatic send_tick(input logic [TS_W-1:0] ts, input logic [PRICE_W-1:0] px);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_ch.valid        <= 1'b1;
    tick_ch.timestamp_us <= ts;
    tick_ch.price        <= px;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
  endtask

  task automatic settle(input int extra);
    tick_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [LEN_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(input logic [LEN_W-1:0] len_word, input logic [LEN_W-1:0] per_word);
    logic [63:0]        len;
    logic [63:0]        t;
    logic [PRICE_W-1:0] px;
    longint             nb;
    int                 sent;
    int                 pick;
    settle(500);
    write_reg(REG_BAR_LEN, len_word);
    write_reg(REG_PERIOD, per_word);
    len  = (len_word == '0) ? 64'd1 : 64'(len_word);
    sent = 0;
    while (sent < PHASE_TICKS) begin
      if (sent % 64 == 0) tx_calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      t    = 64'(ts_now);
      if (pick < 40) t = t + draw_upto(len / 4);
      else if (pick < 75) t = t + len + draw_upto(len / 8);
      else if (pick < 85) t = t + len * $urandom_range(2, 8);
      else if (pick < 90) t = (t > len * 2) ? t - draw_upto(len * 2) : draw_upto(t);
      else if (pick < 95) t = {$urandom, $urandom};
      else t = 64'(TS_TOP) - draw_upto(len * 2);
      ts_now = t[TS_W-1:0];
      pick   = $urandom_range(0, 99);
      if (pick < 5) begin
        px = '0;
      end else if (pick < 8) begin
        px = pick[0] ? '1 : 32'd1;
      end else begin
        if (pick < 12) begin
          px_base = $urandom;
        end else begin
          if (pick < 25)
            nb = longint'(px_base) + longint'($urandom_range(0, 2_000_000)) - 64'sd1_000_000;
          else
            nb = longint'(px_base) + longint'($urandom_range(0, 4000)) - 64'sd2000;
          if (nb < 64'sd1) nb = 64'sd1;
          if (nb > 64'sd4294967295) nb = 64'sd4294967295;
          px_base = nb[PRICE_W-1:0];
        end
        px = px_base;
      end
      send_tick(ts_now, px);
      if (px != '0) begin
        sent++;
        if (sent == 100) settle(0);
      end
    end
  endtask

  initial begin
    int gap;
    res_ch.ready <= 1'b0;
    rx_words = 0;
    rx_calm  = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_words % 64 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      gap = rx_calm ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!res_ch.valid) @(posedge clk);
      rx_words++;
      if (rx_words == 200 || rx_words == 900) begin
        res_ch.ready <= 1'b0;
        repeat (1500) @(posedge clk);
      end
    end
  end

  initial begin
    rst_n                <= 1'b0;
    tick_ch.valid        <= 1'b0;
    tick_ch.timestamp_us <= '0;
    tick_ch.price        <= '0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.index         <= REG_BAR_LEN;
    cfg_ch.data          <= '0;
    tx_calm = 1'b0;
    ts_now  = '0;
    px_base = 32'd1_000_000;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // drop before any bar, open, close and seed, backward buckets, extremes
    send_tick('0, '0);
    send_tick('0, 32'd1);
    send_tick(56'd5, '1);
    send_tick(56'd899_999_999, 32'h8000_0000);
    send_tick(56'd900_000_000, 32'h0000_0100);
    send_tick(56'd900_000_001, '0);
    send_tick(56'd1_800_000_000, 32'h7FFF_FFFF);
    send_tick(56'd1_800_000_000, 32'd1);
    send_tick('0, 32'd300);
    send_tick(TS_TOP, '1);
    send_tick(TS_TOP, 32'd1);
    send_tick(TS_TOP - 56'd900_000_000, 32'hAAAA_AAAA);
    send_tick(56'h55_5555_5555_5555, 32'h5555_5555);
    send_tick(56'hAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA);
    send_tick(56'd2_700_000_000, 32'd2);

    run_phase(37'd1, 37'd1);
    run_phase('0, '0);
    run_phase(37'd86_400_000_000, 37'd255);
    run_phase('1, ({$urandom, $urandom} & ~37'hFF) | 37'd3);
    run_phase(37'd1000, 37'd14);
    run_phase(37'd60_000_000, 37'd2);
    run_phase(37'd7, 37'd255);
    run_phase(BAR_LEN_RST, 37'(PERIOD_RST));

    settle(300);
    if (fail_count == 0 && pending == 0) begin
      $display("bucketed_true_range_wilder_atr verification clean");
    end else begin
      $display("bucketed_true_range_wilder_atr verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/bta_pkg.sv
hw/rtl/bta_tick_if.sv
hw/rtl/bta_res_if.sv
hw/rtl/bta_cfg_if.sv
hw/rtl/bta_front.sv
hw/rtl/bta_div.sv
hw/rtl/bta_back.sv
hw/rtl/bucketed_true_range_wilder_atr.sv
test/bucketed_true_range_wilder_atr_checker.sv
test/bucketed_true_range_wilder_atr_tb.sv
